/* rtl/bvrs_pkg.sv */
// bitvector rank/select package: field widths, op and micro-op codes,
// controller/datapath command and status types, popcount helpers
// no dependencies
package bvrs_pkg;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 14;
  localparam int WORD_W    = 64;
  localparam int POS_W     = 20;
  localparam int CNT_W     = 21;
  localparam int WORD_LOG  = 6;
  localparam int BLOCK_LOG = 2;
  localparam int SB_LOG    = 16;

  localparam int MAX_WORDS   = 1 << IDX_W;
  localparam int BLOCK_WORDS = 1 << BLOCK_LOG;
  localparam int TOTAL_BITS  = MAX_WORDS * WORD_W;
  localparam int BLK_W       = IDX_W - BLOCK_LOG;
  localparam int BLK_DEPTH   = 1 << BLK_W;
  localparam int SB_W        = POS_W - SB_LOG;
  localparam int SB_DEPTH    = 1 << SB_W;
  localparam int SBW_LOG     = SB_LOG - WORD_LOG;
  localparam int NW_W        = IDX_W + 1;
  localparam int NB_W        = NW_W - BLOCK_LOG;
  localparam int PC_W        = WORD_LOG + 1;

  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
  localparam logic [OP_W-1:0] OP_RANK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

  localparam int UOP_W = 5;
  localparam logic [UOP_W-1:0] UOP_NOP    = 5'd0;
  localparam logic [UOP_W-1:0] UOP_ACCEPT = 5'd1;
  localparam logic [UOP_W-1:0] UOP_FAIL   = 5'd2;
  localparam logic [UOP_W-1:0] UOP_BINIT  = 5'd3;
  localparam logic [UOP_W-1:0] UOP_BACC   = 5'd4;
  localparam logic [UOP_W-1:0] UOP_BEND   = 5'd5;
  localparam logic [UOP_W-1:0] UOP_RINIT  = 5'd6;
  localparam logic [UOP_W-1:0] UOP_RBASE  = 5'd7;
  localparam logic [UOP_W-1:0] UOP_RACC   = 5'd8;
  localparam logic [UOP_W-1:0] UOP_SINIT  = 5'd9;
  localparam logic [UOP_W-1:0] UOP_SMID   = 5'd10;
  localparam logic [UOP_W-1:0] UOP_SCMP   = 5'd11;
  localparam logic [UOP_W-1:0] UOP_SFIX   = 5'd12;
  localparam logic [UOP_W-1:0] UOP_SACC   = 5'd13;
  localparam logic [UOP_W-1:0] UOP_NINIT  = 5'd14;
  localparam logic [UOP_W-1:0] UOP_NACC   = 5'd15;
  localparam logic [UOP_W-1:0] UOP_BYTE   = 5'd16;
  localparam logic [UOP_W-1:0] UOP_OUT    = 5'd17;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
  } dp_cmd_t;

  typedef struct packed {
    logic            w_end;
    logic            at_tgt;
    logic            srch_done;
    logic            sel_hit;
    logic            nx_nz;
    logic            byte_hit;
    logic            q_ok;
    logic [OP_W-1:0] op;
  } dp_stat_t;

  function automatic logic [PC_W-1:0] pop64(input logic [WORD_W-1:0] x);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) c = c + PC_W'(x[i]);
    return c;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = c + 4'(x[i]);
    return c;
  endfunction

  // bit index of the rem-th one in a byte, rem from 1
  function automatic logic [2:0] sel8(input logic [7:0] x, input logic [3:0] rem);
    logic [3:0] c;
    logic [2:0] k;
    c = '0;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        c = c + 4'd1;
        if (c == rem) k = 3'(i);
      end
    end
    return k;
  endfunction

endpackage

/* rtl/bvrs_dp.sv */
// bitvector rank/select datapath: word and block count memories,
// superblock counts, counters, popcount and byte select logic
// depends on bvrs_pkg
module bvrs_dp import bvrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_word_index,
  input  logic [WORD_W-1:0] in_word_data,
  input  logic [POS_W-1:0]  in_position,
  input  logic [CNT_W-1:0]  in_select_count,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  output dp_stat_t          stat,
  output logic [CNT_W-1:0]  out_answer,
  output logic              out_found
);

  logic [WORD_W-1:0] wmem [MAX_WORDS];
  logic [SB_LOG-1:0] bmem [BLK_DEPTH];
  logic [CNT_W-1:0]  sb_r [SB_DEPTH];

  logic [CNT_W-1:0]  len_r, total_r;
  logic              ready_r;
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  sel_r;
  logic [NW_W-1:0]   w_r;
  logic [CNT_W-1:0]  run_r, acc_r, rem_r, base_lo_r;
  logic [BLK_W-1:0]  lo_r, hi_r, mid_r;
  logic [WORD_W-1:0] word_r, wrd_q;
  logic [SB_LOG-1:0] bq;
  logic [2:0]        byte_r;
  logic              first_r;
  logic [CNT_W-1:0]  res_ans_r, out_ans_r;
  logic              res_fnd_r, out_fnd_r;

  logic [CNT_W-1:0]    eff;
  logic [CNT_W:0]      nw_sum;
  logic [NW_W-1:0]     nw;
  logic [NW_W:0]       nb_sum;
  logic [NB_W-1:0]     nb, nb_m1;
  logic [WORD_LOG-1:0] tail;
  logic                is_last;
  logic [WORD_W-1:0]   tail_mask, pos_mask, first_mask, nx_m;
  logic [BLK_W-1:0]    baddr, mid;
  logic [BLK_W:0]      mid_sum;
  logic [PC_W-1:0]     p_word, p_tail, p_rank;
  logic [7:0]          byte_v;
  logic [3:0]          p8;
  logic [2:0]          k8;
  logic                sb_new;
  logic [CNT_W-1:0]    sbv, blk_diff, sbase, rsum;
  logic                q_ok;

  assign eff     = (len_r > CNT_W'(TOTAL_BITS)) ? CNT_W'(TOTAL_BITS) : len_r;
  assign nw_sum  = {1'b0, eff} + (CNT_W+1)'(WORD_W - 1);
  assign nw      = nw_sum[WORD_LOG +: NW_W];
  assign nb_sum  = {1'b0, nw} + (NW_W+1)'(BLOCK_WORDS - 1);
  assign nb      = nb_sum[BLOCK_LOG +: NB_W];
  assign nb_m1   = nb - NB_W'(1);
  assign tail    = eff[WORD_LOG-1:0];
  assign is_last = (w_r == nw - NW_W'(1)) && (tail != '0);

  assign tail_mask  = is_last ? ~({WORD_W{1'b1}} << tail) : {WORD_W{1'b1}};
  assign pos_mask   = ~({WORD_W{1'b1}} << ({1'b0, pos_r[WORD_LOG-1:0]} + PC_W'(1)));
  assign first_mask = first_r ? ({WORD_W{1'b1}} << pos_r[WORD_LOG-1:0]) : {WORD_W{1'b1}};
  assign nx_m       = wrd_q & first_mask & tail_mask;

  assign baddr   = (op_r == OP_SELECT) ? mid_r : pos_r[POS_W-1 -: BLK_W];
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (BLK_W+1)'(1);
  assign mid     = mid_sum[BLK_W:1];

  assign p_word = pop64(wrd_q);
  assign p_tail = pop64(wrd_q & tail_mask);
  assign p_rank = pop64(wrd_q & (stat.at_tgt ? pos_mask : {WORD_W{1'b1}}));
  assign rsum   = acc_r + CNT_W'(p_rank);

  assign byte_v = word_r[{byte_r, 3'b000} +: 8];
  assign p8     = pop8(byte_v);
  assign k8     = sel8(byte_v, rem_r[3:0]);

  assign sb_new   = (w_r[SBW_LOG-1:0] == '0);
  assign sbv      = sb_new ? run_r : sb_r[w_r[IDX_W-1 -: SB_W]];
  assign blk_diff = run_r - sbv;
  assign sbase    = sb_r[mid_r[BLK_W-1 -: SB_W]] + CNT_W'(bq);

  always_comb begin
    unique case (op_r)
      OP_RANK, OP_NEXT: q_ok = ready_r && ({1'b0, pos_r} < eff);
      OP_SELECT:        q_ok = ready_r && (sel_r != '0) && (sel_r <= total_r);
      default:          q_ok = 1'b0;
    endcase
  end

  assign stat.w_end     = (w_r >= nw);
  assign stat.at_tgt    = (w_r[IDX_W-1:0] == pos_r[POS_W-1:WORD_LOG]);
  assign stat.srch_done = (lo_r == hi_r);
  assign stat.sel_hit   = (CNT_W'(p_word) >= rem_r);
  assign stat.nx_nz     = (nx_m != '0);
  assign stat.byte_hit  = (CNT_W'(p8) >= rem_r);
  assign stat.q_ok      = q_ok;
  assign stat.op        = op_r;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_ACCEPT && in_op == OP_LOAD) wmem[in_word_index] <= in_word_data;
    wrd_q <= wmem[w_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_BACC && w_r[BLOCK_LOG-1:0] == '0)
      bmem[w_r[IDX_W-1:BLOCK_LOG]] <= blk_diff[SB_LOG-1:0];
    bq <= bmem[baddr];
  end

  // register state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      total_r <= '0;
      ready_r <= 1'b0;
    end else if (cfg_we) begin
      len_r   <= cfg_data;
      ready_r <= 1'b0;
    end else if (cmd.uop == UOP_ACCEPT && in_op == OP_LOAD) begin
      ready_r <= 1'b0;
    end else if (cmd.uop == UOP_BEND) begin
      total_r <= acc_r;
      ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.uop)
      UOP_ACCEPT: begin
        op_r  <= in_op;
        pos_r <= in_position;
        sel_r <= in_select_count;
      end
      UOP_BINIT: begin
        w_r   <= '0;
        run_r <= '0;
        acc_r <= '0;
      end
      UOP_BACC: begin
        if (sb_new) sb_r[w_r[IDX_W-1 -: SB_W]] <= run_r;
        run_r <= run_r + CNT_W'(p_word);
        acc_r <= acc_r + CNT_W'(p_tail);
        w_r   <= w_r + NW_W'(1);
      end
      UOP_BEND: begin
        res_ans_r <= acc_r;
        res_fnd_r <= 1'b1;
      end
      UOP_RINIT: w_r <= NW_W'({pos_r[POS_W-1 -: BLK_W], {BLOCK_LOG{1'b0}}});
      UOP_RBASE: acc_r <= sb_r[pos_r[POS_W-1 -: SB_W]] + CNT_W'(bq);
      UOP_RACC: begin
        acc_r <= rsum;
        if (stat.at_tgt) begin
          res_ans_r <= rsum;
          res_fnd_r <= 1'b1;
        end else begin
          w_r <= w_r + NW_W'(1);
        end
      end
      UOP_SINIT: begin
        lo_r      <= '0;
        hi_r      <= nb_m1[BLK_W-1:0];
        base_lo_r <= '0;
      end
      UOP_SMID: mid_r <= mid;
      UOP_SCMP: begin
        if (sbase < sel_r) begin
          lo_r      <= mid_r;
          base_lo_r <= sbase;
        end else begin
          hi_r <= mid_r - BLK_W'(1);
        end
      end
      UOP_SFIX: begin
        rem_r <= sel_r - base_lo_r;
        w_r   <= NW_W'({lo_r, {BLOCK_LOG{1'b0}}});
      end
      UOP_SACC: begin
        if (stat.sel_hit) begin
          word_r <= wrd_q;
          byte_r <= '0;
        end else begin
          rem_r <= rem_r - CNT_W'(p_word);
          w_r   <= w_r + NW_W'(1);
        end
      end
      UOP_NINIT: begin
        w_r     <= NW_W'(pos_r[POS_W-1:WORD_LOG]);
        first_r <= 1'b1;
      end
      UOP_NACC: begin
        if (stat.nx_nz) begin
          word_r <= nx_m;
          rem_r  <= CNT_W'(1);
          byte_r <= '0;
        end else begin
          w_r     <= w_r + NW_W'(1);
          first_r <= 1'b0;
        end
      end
      UOP_BYTE: begin
        if (stat.byte_hit) begin
          res_ans_r <= CNT_W'({w_r[IDX_W-1:0], byte_r, k8});
          res_fnd_r <= 1'b1;
        end else begin
          rem_r  <= rem_r - CNT_W'(p8);
          byte_r <= byte_r + 3'd1;
        end
      end
      UOP_FAIL: begin
        res_ans_r <= '0;
        res_fnd_r <= 1'b0;
      end
      UOP_OUT: begin
        out_ans_r <= res_ans_r;
        out_fnd_r <= res_fnd_r;
      end
      default: ;
    endcase
  end

  assign out_answer = out_ans_r;
  assign out_found  = out_fnd_r;

endmodule

/* rtl/bvrs_ctrl.sv */
// bitvector rank/select controller: sequences build, rank, select and
// next-one work as datapath commands, owns the handshakes
// depends on bvrs_pkg
module bvrs_ctrl import bvrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_op,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_BLD_INIT = 5'd1;
  localparam logic [4:0] S_BLD_CHK  = 5'd2;
  localparam logic [4:0] S_BLD_ACC  = 5'd3;
  localparam logic [4:0] S_BLD_END  = 5'd4;
  localparam logic [4:0] S_Q_CHK    = 5'd5;
  localparam logic [4:0] S_RK_INIT  = 5'd6;
  localparam logic [4:0] S_RK_BASE  = 5'd7;
  localparam logic [4:0] S_RK_ACC   = 5'd8;
  localparam logic [4:0] S_RK_WAIT  = 5'd9;
  localparam logic [4:0] S_SL_INIT  = 5'd10;
  localparam logic [4:0] S_SL_CHK   = 5'd11;
  localparam logic [4:0] S_SL_WAIT  = 5'd12;
  localparam logic [4:0] S_SL_CMP   = 5'd13;
  localparam logic [4:0] S_SL_FIX   = 5'd14;
  localparam logic [4:0] S_SL_RD    = 5'd15;
  localparam logic [4:0] S_SL_ACC   = 5'd16;
  localparam logic [4:0] S_NX_INIT  = 5'd17;
  localparam logic [4:0] S_NX_CHK   = 5'd18;
  localparam logic [4:0] S_NX_ACC   = 5'd19;
  localparam logic [4:0] S_BYTE     = 5'd20;
  localparam logic [4:0] S_FAIL     = 5'd21;
  localparam logic [4:0] S_FIN      = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.uop       = UOP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.uop = UOP_ACCEPT;
          unique case (in_op)
            OP_BUILD:                    state_nxt = S_BLD_INIT;
            OP_RANK, OP_SELECT, OP_NEXT: state_nxt = S_Q_CHK;
            default:                     state_nxt = S_IDLE;
          endcase
        end
      end
      S_BLD_INIT: begin
        cmd.uop   = UOP_BINIT;
        state_nxt = S_BLD_CHK;
      end
      S_BLD_CHK: state_nxt = stat.w_end ? S_BLD_END : S_BLD_ACC;
      S_BLD_ACC: begin
        cmd.uop   = UOP_BACC;
        state_nxt = S_BLD_CHK;
      end
      S_BLD_END: begin
        cmd.uop   = UOP_BEND;
        state_nxt = S_FIN;
      end
      S_Q_CHK: begin
        if (!stat.q_ok) begin
          state_nxt = S_FAIL;
        end else begin
          unique case (stat.op)
            OP_RANK:   state_nxt = S_RK_INIT;
            OP_SELECT: state_nxt = S_SL_INIT;
            OP_NEXT:   state_nxt = S_NX_INIT;
            default:   state_nxt = S_FAIL;
          endcase
        end
      end
      S_RK_INIT: begin
        cmd.uop   = UOP_RINIT;
        state_nxt = S_RK_BASE;
      end
      S_RK_BASE: begin
        cmd.uop   = UOP_RBASE;
        state_nxt = S_RK_ACC;
      end
      S_RK_ACC: begin
        cmd.uop   = UOP_RACC;
        state_nxt = stat.at_tgt ? S_FIN : S_RK_WAIT;
      end
      S_RK_WAIT: state_nxt = S_RK_ACC;
      S_SL_INIT: begin
        cmd.uop   = UOP_SINIT;
        state_nxt = S_SL_CHK;
      end
      S_SL_CHK: begin
        if (stat.srch_done) begin
          state_nxt = S_SL_FIX;
        end else begin
          cmd.uop   = UOP_SMID;
          state_nxt = S_SL_WAIT;
        end
      end
      S_SL_WAIT: state_nxt = S_SL_CMP;
      S_SL_CMP: begin
        cmd.uop   = UOP_SCMP;
        state_nxt = S_SL_CHK;
      end
      S_SL_FIX: begin
        cmd.uop   = UOP_SFIX;
        state_nxt = S_SL_RD;
      end
      S_SL_RD: state_nxt = S_SL_ACC;
      S_SL_ACC: begin
        if (stat.w_end) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.uop   = UOP_SACC;
          state_nxt = stat.sel_hit ? S_BYTE : S_SL_RD;
        end
      end
      S_NX_INIT: begin
        cmd.uop   = UOP_NINIT;
        state_nxt = S_NX_CHK;
      end
      S_NX_CHK: state_nxt = stat.w_end ? S_FAIL : S_NX_ACC;
      S_NX_ACC: begin
        cmd.uop   = UOP_NACC;
        state_nxt = stat.nx_nz ? S_BYTE : S_NX_CHK;
      end
      S_BYTE: begin
        cmd.uop   = UOP_BYTE;
        state_nxt = stat.byte_hit ? S_FIN : S_BYTE;
      end
      S_FAIL: begin
        cmd.uop   = UOP_FAIL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.uop       = UOP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/bitvector_rank_select.sv */
// bitvector rank/select engine, top level
// depends on bvrs_pkg, bvrs_ctrl, bvrs_dp
//
// channel  ports          fields (low bit first)
// input    in_t*          tuser: op; tdata: word_index, word_data, position, select_count
// result   out_t*         tuser: found; tdata: answer
// config   cfg_*          cfg_data: bit_length
//
// load: writes one word. build: reads every word below bit_length (word memory read loop).
// rank: block count read, then up to 4 word popcounts.
// select: block search (12 steps), then a word scan and a byte scan.
// next one: word scan, then up to 8 byte steps.
// one item at a time; a finished result waits in the output register while
// the next item is taken. memories hold no reset and need no clearing pass.
module bitvector_rank_select import bvrs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // word_index, word_data, position, select_count
  input  logic [2:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // answer
  output logic [0:0]   out_tuser,  // found
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [20:0]  cfg_data
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CNT_W-1:0] answer;
  logic             found;

  assign cfg_ready = 1'b1;

  bvrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bvrs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_tuser),
    .in_word_index   (in_tdata[13:0]),
    .in_word_data    (in_tdata[77:14]),
    .in_position     (in_tdata[97:78]),
    .in_select_count (in_tdata[118:98]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .stat            (stat),
    .out_answer      (answer),
    .out_found       (found)
  );

  assign out_tdata = {3'b000, answer};
  assign out_tuser = found;

`ifndef NO_ASSERTIONS
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_LOAD && !out_tvalid) |=> !out_tvalid)
    else $error("load produced a result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("answer not zero when not found");
`endif

endmodule
